// File: sv/iht_pkg.sv
package iht_pkg;

    localparam int GRAY_LEVELS          = 256;
    localparam int LVL_W                = 8;
    localparam int ITER_W               = 10;
    localparam int DEF_MAX_FRAME_PIXELS = 1048575;
    localparam int APB_ADDR_W           = 4;

    localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 10'd1000;
    localparam logic [LVL_W-1:0]  LVL_MAX        = 8'd255;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] REG_USE_FIXED = 4'h0;
    localparam logic [APB_ADDR_W-1:0] REG_START_THR = 4'h4;
    localparam logic [APB_ADDR_W-1:0] REG_ITER_LIM  = 4'h8;

    localparam logic OP_ACCUM    = 1'b0;
    localparam logic OP_BINARIZE = 1'b1;

    typedef struct packed {
        logic              use_fixed_start;
        logic [LVL_W-1:0]  start_threshold;
        logic [ITER_W-1:0] iteration_limit;
    } iht_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_START,
        ST_CHECK,
        ST_SWEEP,
        ST_DIV,
        ST_WAIT,
        ST_EVAL,
        ST_REPORT
    } iht_state_t;

endpackage

// File: sv/iterative_histogram_threshold_unit.sv
// Channel | Direction | Handshake       | Payload
// s_      | in        | s_valid/s_ready | s_op, s_pixel_value, s_frame_end
// m_      | out       | m_valid/m_ready | m_is_report, m_binary_pixel, m_threshold_value,
//         |           |                 | m_mean_low, m_mean_high, m_converged
// apb     | in        | psel/penable    | paddr, pwdata, prdata
//
// Binarize transaction: compare and register the result. Accumulate transaction: RAM read, then write back.
// Search on frame_end: a start state, a full-histogram sweep and divide for a mean-level start, then
// per iteration a bin sweep, an 8-step divider and the check and evaluate control states, then a report
// state and a clearing pass of the histogram RAM.
// After reset a clearing pass runs before the first transaction is taken.
// A stalled result holds in the output register and blocks new input until it is taken.
module iterative_histogram_threshold_unit
    import iht_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [LVL_W-1:0]      s_pixel_value,
    input  logic                  s_frame_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_report,
    output logic [LVL_W-1:0]      m_binary_pixel,
    output logic [LVL_W-1:0]      m_threshold_value,
    output logic [LVL_W-1:0]      m_mean_low,
    output logic [LVL_W-1:0]      m_mean_high,
    output logic                  m_converged
);

    localparam int BIN_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SUM_W = BIN_W + 2 * LVL_W;
    localparam int CNT_W = BIN_W + LVL_W;
    localparam int IDX_W = LVL_W + 1;
    localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(MAX_FRAME_PIXELS);

    iht_cfg_t   cfg;
    iht_state_t state_reg, state_next;

    logic [IDX_W-1:0]  idx_reg;
    logic              p_vld_reg;
    logic [LVL_W-1:0]  p_idx_reg;
    logic [LVL_W-1:0]  pix_reg;
    logic              fend_reg;
    logic [LVL_W-1:0]  thr_reg;
    logic [LVL_W-1:0]  prev_lo_reg, prev_hi_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              full_reg;
    logic              conv_reg;
    logic [SUM_W-1:0]  sum_lo_reg, sum_hi_reg;
    logic [CNT_W-1:0]  cnt_lo_reg, cnt_hi_reg;

    logic              m_valid_reg;
    logic              m_is_report_reg, m_conv_reg;
    logic [LVL_W-1:0]  m_bin_reg, m_thr_reg, m_lo_reg, m_hi_reg;

    logic              ram_we;
    logic [LVL_W-1:0]  ram_waddr, ram_raddr;
    logic [BIN_W-1:0]  ram_wdata, ram_rdata;
    logic              div_start, done_lo, done_hi;
    logic [LVL_W-1:0]  q_lo, q_hi;
    logic              s_fire, out_free;
    logic [SUM_W-1:0]  prod;
    logic [LVL_W:0]    mid;

    iht_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    iht_ram #(.WIDTH(BIN_W), .DEPTH(GRAY_LEVELS)) u_hist (
        .aclk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    iht_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_lo (
        .aclk, .aresetn, .start(div_start), .dividend(sum_lo_reg),
        .divisor(cnt_lo_reg), .done(done_lo), .quotient(q_lo)
    );

    iht_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_hi (
        .aclk, .aresetn, .start(div_start), .dividend(sum_hi_reg),
        .divisor(cnt_hi_reg), .done(done_hi), .quotient(q_hi)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;
    assign prod     = SUM_W'(p_idx_reg) * SUM_W'(ram_rdata);
    assign mid      = (LVL_W + 1)'(q_lo) + (LVL_W + 1)'(q_hi);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (idx_reg == IDX_W'(GRAY_LEVELS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_fire && s_op == OP_ACCUM) state_next = ST_ACC;
            ST_ACC:    state_next = fend_reg ? ST_START : ST_IDLE;
            ST_START:  state_next = cfg.use_fixed_start ? ST_CHECK : ST_SWEEP;
            ST_CHECK:  state_next = (iter_reg == '0) ? ST_REPORT : ST_SWEEP;
            ST_SWEEP:  if (idx_reg == IDX_W'(GRAY_LEVELS)) state_next = ST_DIV;
            ST_DIV:    state_next = ST_WAIT;
            ST_WAIT:   if (done_lo && done_hi) state_next = full_reg ? ST_CHECK : ST_EVAL;
            ST_EVAL:   state_next = (q_lo == prev_lo_reg && q_hi == prev_hi_reg)
                                    ? ST_REPORT : ST_CHECK;
            ST_REPORT: if (out_free) state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM and divider controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[LVL_W-1:0];
        ram_wdata = '0;
        ram_raddr = idx_reg[LVL_W-1:0];
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR: ram_we = 1'b1;
            ST_IDLE:  ram_raddr = s_pixel_value;
            ST_ACC: begin
                ram_we    = 1'b1;
                ram_waddr = pix_reg;
                ram_wdata = (ram_rdata < BIN_MAX) ? ram_rdata + 1'b1 : ram_rdata;
            end
            ST_DIV:   div_start = 1'b1;
            default: ;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            p_vld_reg   <= 1'b0;
            thr_reg     <= '0;
            prev_lo_reg <= '0;
            prev_hi_reg <= '0;
            iter_reg    <= '0;
            full_reg    <= 1'b0;
            conv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_vld_reg <= (state_reg == ST_SWEEP) && (idx_reg != IDX_W'(GRAY_LEVELS));
            p_idx_reg <= idx_reg[LVL_W-1:0];

            // bin accumulation in the cycle after the RAM read
            if (p_vld_reg) begin
                if (full_reg || p_idx_reg < thr_reg) begin
                    sum_lo_reg <= sum_lo_reg + prod;
                    cnt_lo_reg <= cnt_lo_reg + CNT_W'(ram_rdata);
                end else if (p_idx_reg > thr_reg) begin
                    sum_hi_reg <= sum_hi_reg + prod;
                    cnt_hi_reg <= cnt_hi_reg + CNT_W'(ram_rdata);
                end
            end

            unique case (state_reg)
                ST_CLEAR: idx_reg <= idx_reg + 1'b1;
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (s_fire) begin
                        pix_reg  <= s_pixel_value;
                        fend_reg <= s_frame_end;
                    end
                end
                ST_START: begin
                    thr_reg     <= cfg.start_threshold;
                    prev_lo_reg <= '0;
                    prev_hi_reg <= '0;
                    iter_reg    <= cfg.iteration_limit;
                    full_reg    <= !cfg.use_fixed_start;
                    conv_reg    <= 1'b0;
                    idx_reg     <= '0;
                    sum_lo_reg  <= '0;
                    sum_hi_reg  <= '0;
                    cnt_lo_reg  <= '0;
                    cnt_hi_reg  <= '0;
                end
                ST_CHECK: begin
                    idx_reg    <= '0;
                    sum_lo_reg <= '0;
                    sum_hi_reg <= '0;
                    cnt_lo_reg <= '0;
                    cnt_hi_reg <= '0;
                end
                ST_SWEEP: idx_reg <= idx_reg + 1'b1;
                ST_WAIT: begin
                    if (done_lo && done_hi && full_reg) begin
                        thr_reg  <= q_lo;
                        full_reg <= 1'b0;
                    end
                end
                ST_EVAL: begin
                    if (q_lo == prev_lo_reg && q_hi == prev_hi_reg) begin
                        conv_reg <= 1'b1;
                    end else begin
                        prev_lo_reg <= q_lo;
                        prev_hi_reg <= q_hi;
                        thr_reg     <= mid[LVL_W:1];
                        iter_reg    <= iter_reg - 1'b1;
                    end
                end
                ST_REPORT: idx_reg <= '0;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_op == OP_BINARIZE) begin
            m_valid_reg     <= 1'b1;
            m_is_report_reg <= 1'b0;
            m_bin_reg       <= (s_pixel_value >= thr_reg) ? LVL_MAX : '0;
            m_thr_reg       <= thr_reg;
            m_lo_reg        <= '0;
            m_hi_reg        <= '0;
            m_conv_reg      <= 1'b0;
        end else if (state_reg == ST_REPORT && out_free) begin
            m_valid_reg     <= 1'b1;
            m_is_report_reg <= 1'b1;
            m_bin_reg       <= '0;
            m_thr_reg       <= thr_reg;
            m_lo_reg        <= prev_lo_reg;
            m_hi_reg        <= prev_hi_reg;
            m_conv_reg      <= conv_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_is_report       = m_is_report_reg;
    assign m_binary_pixel    = m_bin_reg;
    assign m_threshold_value = m_thr_reg;
    assign m_mean_low        = m_lo_reg;
    assign m_mean_high       = m_hi_reg;
    assign m_converged       = m_conv_reg;

endmodule

// File: sv/iht_ram.sv
module iht_ram
    import iht_pkg::*;
#(
    parameter int WIDTH = 20,
    parameter int DEPTH = GRAY_LEVELS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/iht_div.sv
module iht_div
    import iht_pkg::*;
#(
    parameter int SUM_W = 36,
    parameter int CNT_W = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [LVL_W-1:0] quotient
);

    localparam int STEP_W = $clog2(LVL_W + 1);

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  sh_reg;
    logic [LVL_W-1:0]  q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              zero_reg;
    logic              done_reg;
    logic              ge;

    // restoring division, one quotient bit a cycle; mean never exceeds 255
    assign ge = (rem_reg >= sh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(LVL_W);
                rem_reg  <= dividend;
                sh_reg   <= SUM_W'(divisor) << (LVL_W - 1);
                zero_reg <= (divisor == '0);
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - sh_reg;
                end
                q_reg    <= {q_reg[LVL_W-2:0], ge};
                sh_reg   <= sh_reg >> 1;
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

// File: sv/iht_cfg.sv
module iht_cfg
    import iht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output iht_cfg_t              cfg
);

    iht_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.use_fixed_start <= 1'b0;
            cfg_reg.start_threshold <= '0;
            cfg_reg.iteration_limit <= ITER_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                REG_USE_FIXED: cfg_reg.use_fixed_start <= pwdata[0];
                REG_START_THR: cfg_reg.start_threshold <= pwdata[LVL_W-1:0];
                REG_ITER_LIM:  cfg_reg.iteration_limit <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr)
            REG_USE_FIXED: prdata = 32'(cfg_reg.use_fixed_start);
            REG_START_THR: prdata = 32'(cfg_reg.start_threshold);
            REG_ITER_LIM:  prdata = 32'(cfg_reg.iteration_limit);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule
